### rtl/utde_pkg.sv
// Shared types and calendar tables for the UTC date to epoch seconds converter.
package utde_pkg;

    localparam logic [16:0] EpochDayNum = 17'd29951;  // day number of 1970-01-01
    localparam logic [8:0]  YoffFirst   = 9'd82;      // offset year of 1970
    localparam logic [8:0]  YoffLast    = 9'd217;     // offset year of 2105

    typedef struct packed {
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hour;
        logic signed [10:0] mday;
        logic [3:0]        mon;
        logic [8:0]        yoff;   // years since 1900 plus 12, keeps it positive
    } norm_t;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [16:0] dnum;         // days since offset year zero
    } dnum_t;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  mon;
        logic [7:0]  year;
        logic [8:0]  yday;
        logic [15:0] days;
        logic        oor;
    } date_t;

    // days before the first of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            4'd11:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && m >= 4'd2)
        begin
            c = c + 9'd1;
        end
        return c;
    endfunction

endpackage

### rtl/utde_carry.sv
// Three pipeline stages: second, minute and hour carries plus month to year carry.
module utde_carry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [12:0]  second_in,
    input  logic signed [11:0]  minute_in,
    input  logic signed [10:0]  hour_in,
    input  logic signed [9:0]   mday_in,
    input  logic signed [6:0]   month_in,
    input  logic [7:0]          year_in,
    output logic                out_valid,
    output utde_pkg::norm_t     out_norm
);
    import utde_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic [5:0]         sec1_reg, sec2_reg, sec3_reg;
    logic signed [12:0] min1_reg;
    logic [5:0]         min2_reg, min3_reg;
    logic signed [10:0] hour1_reg;
    logic signed [11:0] hour2_reg;
    logic [4:0]         hour3_reg;
    logic signed [9:0]  mday1_reg, mday2_reg;
    logic signed [10:0] mday3_reg;
    logic [3:0]         mon1_reg, mon2_reg, mon3_reg;
    logic [8:0]         yoff1_reg, yoff2_reg, yoff3_reg;

    // stage 1
    logic signed [13:0] sx;
    logic [13:0]        xs, rs0;
    logic [28:0]        ps;
    logic [7:0]         qs0, qs;
    logic [5:0]         sec1_next;
    logic signed [12:0] min1_next;
    logic signed [8:0]  mx;
    logic [7:0]         xm, rm0;
    logic [24:0]        pm;
    logic [3:0]         qm0, qm, mon1_next;
    logic [8:0]         yoff1_next;

    always_comb
    begin
        // floor divide by 60 through an offset that makes the value positive
        sx  = 14'(second_in) + 14'sd4140;
        xs  = $unsigned(sx);
        ps  = 29'(xs) * 29'd17476;
        qs0 = ps[27:20];
        rs0 = xs - 14'(qs0) * 14'd60;
        if (rs0 >= 14'd60)
        begin
            qs        = qs0 + 8'd1;
            sec1_next = 6'(rs0 - 14'd60);
        end
        else
        begin
            qs        = qs0;
            sec1_next = rs0[5:0];
        end
        min1_next = 13'(minute_in) + $signed({5'b0, qs}) - 13'sd69;

        mx  = 9'(month_in) + 9'sd72;
        xm  = mx[7:0];
        pm  = 25'(xm) * 25'd87381;
        qm0 = pm[23:20];
        rm0 = xm - 8'(qm0) * 8'd12;
        if (rm0 >= 8'd12)
        begin
            qm        = qm0 + 4'd1;
            mon1_next = 4'(rm0 - 8'd12);
        end
        else
        begin
            qm        = qm0;
            mon1_next = rm0[3:0];
        end
        yoff1_next = 9'(year_in) + 9'(qm) + 9'd6;
    end

    // stage 2
    logic signed [13:0] mx2;
    logic [12:0]        xmin, rmin0;
    logic [27:0]        pmin;
    logic [6:0]         qmin0, qmin;
    logic [5:0]         min2_next;
    logic signed [11:0] hour2_next;

    always_comb
    begin
        mx2   = 14'(min1_reg) + 14'sd2160;
        xmin  = mx2[12:0];
        pmin  = 28'(xmin) * 28'd17476;
        qmin0 = pmin[26:20];
        rmin0 = xmin - 13'(qmin0) * 13'd60;
        if (rmin0 >= 13'd60)
        begin
            qmin      = qmin0 + 7'd1;
            min2_next = 6'(rmin0 - 13'd60);
        end
        else
        begin
            qmin      = qmin0;
            min2_next = rmin0[5:0];
        end
        hour2_next = 12'(hour1_reg) + $signed({5'b0, qmin}) - 12'sd36;
    end

    // stage 3
    logic signed [12:0] hx;
    logic [11:0]        xh, rh0;
    logic [27:0]        ph;
    logic [6:0]         qh0, qh;
    logic [4:0]         hour3_next;
    logic signed [10:0] mday3_next;

    always_comb
    begin
        hx  = 13'(hour2_reg) + 13'sd1104;
        xh  = hx[11:0];
        ph  = 28'(xh) * 28'd43690;
        qh0 = ph[26:20];
        rh0 = xh - 12'(qh0) * 12'd24;
        if (rh0 >= 12'd24)
        begin
            qh         = qh0 + 7'd1;
            hour3_next = 5'(rh0 - 12'd24);
        end
        else
        begin
            qh         = qh0;
            hour3_next = rh0[4:0];
        end
        mday3_next = 11'(mday2_reg) + $signed({4'b0, qh}) - 11'sd46;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec1_reg  <= sec1_next;
            min1_reg  <= min1_next;
            hour1_reg <= hour_in;
            mday1_reg <= mday_in;
            mon1_reg  <= mon1_next;
            yoff1_reg <= yoff1_next;

            sec2_reg  <= sec1_reg;
            min2_reg  <= min2_next;
            hour2_reg <= hour2_next;
            mday2_reg <= mday1_reg;
            mon2_reg  <= mon1_reg;
            yoff2_reg <= yoff1_reg;

            sec3_reg  <= sec2_reg;
            min3_reg  <= min2_reg;
            hour3_reg <= hour3_next;
            mday3_reg <= mday3_next;
            mon3_reg  <= mon2_reg;
            yoff3_reg <= yoff2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign out_norm.sec  = sec3_reg;
    assign out_norm.min  = min3_reg;
    assign out_norm.hour = hour3_reg;
    assign out_norm.mday = mday3_reg;
    assign out_norm.mon  = mon3_reg;
    assign out_norm.yoff = yoff3_reg;

endmodule

### rtl/utde_daynum.sv
// One pipeline stage: linear day number from offset year, month and day of month.
module utde_daynum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  utde_pkg::norm_t in_norm,
    output logic            out_valid,
    output utde_pkg::dnum_t out_dnum
);
    import utde_pkg::*;

    logic    v_reg;
    dnum_t   d_reg, d_next;
    logic    leap;
    logic [17:0] base;
    logic signed [18:0] t;

    always_comb
    begin
        leap = (in_norm.yoff[1:0] == 2'd0);
        base = 18'(in_norm.yoff) * 18'd365
             + 18'((10'(in_norm.yoff) + 10'd3) >> 2)
             + 18'(cum_days(in_norm.mon, leap));
        t    = $signed({1'b0, base}) + 19'(in_norm.mday) - 19'sd1;
        d_next.sec  = in_norm.sec;
        d_next.min  = in_norm.min;
        d_next.hour = in_norm.hour;
        d_next.dnum = t[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_dnum  = d_reg;

endmodule

### rtl/utde_split.sv
// Five pipeline stages: day number back to year, month, day of month and day of year.
module utde_split (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  utde_pkg::dnum_t in_dnum,
    output logic            out_valid,
    output utde_pkg::date_t out_date
);
    import utde_pkg::*;

    logic v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    dnum_t       d5_reg, d6_reg, d7_reg, d8_reg;
    logic [30:0] prod5_reg;
    logic [6:0]  q6_reg, q7_reg;
    logic [11:0] r6_reg;
    logic [10:0] r7_reg;
    logic [8:0]  doy8_reg, yoff8_reg;
    logic        leap8_reg;
    date_t       date9_reg;

    // stage 6: quotient by 1461 days (four-year cycle), one low at most
    logic [16:0] rem6;
    always_comb
    begin
        rem6 = d5_reg.dnum - 17'(prod5_reg[30:24]) * 17'd1461;
    end

    // stage 8: year within the cycle, leap year first
    logic [1:0]  yo;
    logic [8:0]  doy8_next;
    always_comb
    begin
        if (r7_reg < 11'd366)
        begin
            yo        = 2'd0;
            doy8_next = r7_reg[8:0];
        end
        else if (r7_reg < 11'd731)
        begin
            yo        = 2'd1;
            doy8_next = 9'(r7_reg - 11'd366);
        end
        else if (r7_reg < 11'd1096)
        begin
            yo        = 2'd2;
            doy8_next = 9'(r7_reg - 11'd731);
        end
        else
        begin
            yo        = 2'd3;
            doy8_next = 9'(r7_reg - 11'd1096);
        end
    end

    // stage 9: month search over the cumulative table
    logic [3:0]  mon9;
    logic [8:0]  cum9;
    date_t       date9_next;
    always_comb
    begin
        mon9 = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy8_reg >= cum_days(4'(m), leap8_reg))
            begin
                mon9 = 4'(m);
            end
        end
        cum9 = cum_days(mon9, leap8_reg);
        date9_next.sec  = d8_reg.sec;
        date9_next.min  = d8_reg.min;
        date9_next.hour = d8_reg.hour;
        date9_next.mday = 5'(doy8_reg - cum9 + 9'd1);
        date9_next.mon  = mon9;
        date9_next.year = 8'(yoff8_reg - 9'd12);
        date9_next.yday = doy8_reg;
        date9_next.days = 16'(d8_reg.dnum - EpochDayNum);
        date9_next.oor  = (yoff8_reg < YoffFirst) || (yoff8_reg > YoffLast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= in_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d5_reg    <= in_dnum;
            prod5_reg <= 31'(in_dnum.dnum) * 31'd11483;

            d6_reg <= d5_reg;
            q6_reg <= prod5_reg[30:24];
            r6_reg <= rem6[11:0];

            d7_reg <= d6_reg;
            if (r6_reg >= 12'd1461)
            begin
                q7_reg <= q6_reg + 7'd1;
                r7_reg <= 11'(r6_reg - 12'd1461);
            end
            else
            begin
                q7_reg <= q6_reg;
                r7_reg <= r6_reg[10:0];
            end

            d8_reg    <= d7_reg;
            doy8_reg  <= doy8_next;
            yoff8_reg <= {q7_reg, yo};
            leap8_reg <= (yo == 2'd0);

            date9_reg <= date9_next;
        end
    end

    assign out_valid = v9_reg;
    assign out_date  = date9_reg;

endmodule

### rtl/utde_secs.sv
// Two pipeline stages: seconds since 1970 and the output register.
module utde_secs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  utde_pkg::date_t in_date,
    output logic            out_valid,
    output utde_pkg::date_t out_date,
    output logic [32:0]     out_secs
);
    import utde_pkg::*;

    logic        v10_reg, v11_reg;
    date_t       date10_reg, date11_reg;
    logic [32:0] dprod10_reg, secs11_reg;
    logic [16:0] hms10_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (en)
        begin
            v10_reg <= in_valid;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            date10_reg  <= in_date;
            dprod10_reg <= 33'(in_date.days) * 33'd86400;
            hms10_reg   <= 17'(in_date.hour) * 17'd3600 + 17'(in_date.min) * 17'd60
                         + 17'(in_date.sec);
            date11_reg  <= date10_reg;
            secs11_reg  <= date10_reg.oor ? 33'd0 : dprod10_reg + 33'(hms10_reg);
        end
    end

    assign out_valid = v11_reg;
    assign out_date  = date11_reg;
    assign out_secs  = secs11_reg;

endmodule

### rtl/utc_date_to_epoch_seconds.sv
// Top level of the UTC broken-down time to epoch seconds converter.
// An input transaction reaches out_valid through an 11-stage pipeline.
// Throughput: one transaction per cycle; a stall on the output freezes every stage.
// Normalization is closed form (day number, divide by the 1461-day cycle), no iteration.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
module utc_date_to_epoch_seconds (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [12:0] second_in,
    input  logic signed [11:0] minute_in,
    input  logic signed [10:0] hour_in,
    input  logic signed [9:0]  mday_in,
    input  logic signed [6:0]  month_in,
    input  logic [7:0]         year_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         second_out,
    output logic [5:0]         minute_out,
    output logic [4:0]         hour_out,
    output logic [4:0]         mday_out,
    output logic [3:0]         month_out,
    output logic [7:0]         year_out,
    output logic [8:0]         yday_out,
    output logic [32:0]        epoch_seconds,
    output logic               out_of_range
);
    import utde_pkg::*;

    logic  en;
    logic  carry_valid, day_valid, split_valid;
    norm_t norm;
    dnum_t dnum;
    date_t split_date, final_date;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    utde_carry u_carry (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .second_in (second_in),
        .minute_in (minute_in),
        .hour_in   (hour_in),
        .mday_in   (mday_in),
        .month_in  (month_in),
        .year_in   (year_in),
        .out_valid (carry_valid),
        .out_norm  (norm)
    );

    utde_daynum u_daynum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (carry_valid),
        .in_norm   (norm),
        .out_valid (day_valid),
        .out_dnum  (dnum)
    );

    utde_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (day_valid),
        .in_dnum   (dnum),
        .out_valid (split_valid),
        .out_date  (split_date)
    );

    utde_secs u_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (split_valid),
        .in_date   (split_date),
        .out_valid (out_valid),
        .out_date  (final_date),
        .out_secs  (epoch_seconds)
    );

    assign second_out   = final_date.sec;
    assign minute_out   = final_date.min;
    assign hour_out     = final_date.hour;
    assign mday_out     = final_date.mday;
    assign month_out    = final_date.mon;
    assign year_out     = final_date.year;
    assign yday_out     = final_date.yday;
    assign out_of_range = final_date.oor;

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (epoch_seconds == 33'd0))
        else $error("epoch seconds not zero on out of range year");

    a_time_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_out < 6'd60 && minute_out < 6'd60 && hour_out < 5'd24))
        else $error("time of day not normalized");

    a_date_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_out < 4'd12 && mday_out != 5'd0 && yday_out < 9'd366))
        else $error("date not normalized");

    a_yday_mday: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && month_out == 4'd0) |-> (yday_out == 9'(mday_out) - 9'd1))
        else $error("day of year disagrees with day of month in January");

endmodule
